// ===== rtl/ovle_pkg.sv =====
// ----------------------------------------------------------------------------
// ovle_pkg
// Request and status codes and the control word shared by the list cells.
// ----------------------------------------------------------------------------
package ovle_pkg;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_UPDATE = 2'd2;
	localparam logic [1:0] REQ_SEARCH = 2'd3;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_EMPTY     = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	typedef struct packed {
		logic        cmp_en;
		logic        apply_en;
		logic [1:0]  op;
		logic [31:0] value;
		logic [31:0] new_value;
	} cell_ctl_t;

endpackage

// ===== rtl/ovle_req_if.sv =====
// ----------------------------------------------------------------------------
// ovle_req_if
// Request channel: request kind, match value and replacement value.
// ----------------------------------------------------------------------------
interface ovle_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [31:0] value;
	logic signed [31:0] new_value;

	modport source (output valid, output req_type, output value, output new_value,
		input ready);
	modport sink (input valid, input req_type, input value, input new_value,
		output ready);
endinterface

// ===== rtl/ovle_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ovle_rsp_if
// Result channel: status code and entry count after the request.
// ----------------------------------------------------------------------------
interface ovle_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [4:0] entry_count;

	modport source (output valid, output status, output entry_count, input ready);
	modport sink (input valid, input status, input entry_count, output ready);
endinterface

// ===== rtl/ovle_cell.sv =====
// ----------------------------------------------------------------------------
// ovle_cell
// One list slot: holds an entry, compares it with the request value and
// takes part in the first-match chain that runs from head to tail.
// ----------------------------------------------------------------------------
module ovle_cell import ovle_pkg::*; #(
	parameter int unsigned CNT_W = 5,
	parameter int unsigned IDX   = 0
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [CNT_W-1:0] count,
	input  logic             prior_in,
	input  logic [31:0]      next_data,
	output logic [31:0]      data,
	output logic             prior_out
);

	logic [31:0] data_q;
	logic        match_q;
	logic        in_use;
	logic        first;

	assign in_use    = CNT_W'(IDX) < count;
	assign prior_out = prior_in | match_q;
	assign first     = match_q & ~prior_in;
	assign data      = data_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			match_q <= in_use && (data_q == ctl.value);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.apply_en) begin
			case (ctl.op)
				REQ_ADD: begin
					if (count == CNT_W'(IDX)) begin
						data_q <= ctl.value;
					end
				end
				REQ_REMOVE: begin
					if (prior_out) begin
						data_q <= next_data;
					end
				end
				REQ_UPDATE: begin
					if (first) begin
						data_q <= ctl.new_value;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/ordered_value_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_value_list_engine
// Insertion-ordered list of signed 32-bit values held in a row of cells.
// A request passes through the compare state and then the apply state of the
// cell row; the result is registered on leaving the apply state. A new request
// is taken only in idle, once the previous result has been or is being taken.
// Reset clears the entry count and the handshakes; entry contents are unset.
// ----------------------------------------------------------------------------
module ordered_value_list_engine import ovle_pkg::*; #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ovle_req_if.sink   req,
	ovle_rsp_if.source rsp
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CMP   = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       op_q;
	logic [31:0]      value_q;
	logic [31:0]      new_value_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [4:0]       entry_count_q;

	cell_ctl_t        ctl;
	logic [31:0]      cell_data [CAPACITY];
	logic [CAPACITY:0] prior;
	logic             any_match;
	logic             take;
	logic [1:0]       status_next;
	logic [CNT_W-1:0] count_next;

	assign req.ready       = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign take            = req.valid && req.ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = entry_count_q;

	assign ctl.cmp_en    = state_q == S_CMP;
	assign ctl.apply_en  = state_q == S_APPLY;
	assign ctl.op        = op_q;
	assign ctl.value     = value_q;
	assign ctl.new_value = new_value_q;

	assign prior[0]  = 1'b0;
	assign any_match = prior[CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0] next_data;
		if (i == CAPACITY - 1) begin : g_tail
			assign next_data = cell_data[i];
		end else begin : g_mid
			assign next_data = cell_data[i+1];
		end
		ovle_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count_q),
			.prior_in  (prior[i]),
			.next_data (next_data),
			.data      (cell_data[i]),
			.prior_out (prior[i+1])
		);
	end

	always_comb begin
		status_next = STAT_OK;
		count_next  = count_q;
		case (op_q)
			REQ_ADD: begin
				if (count_q == CNT_W'(CAPACITY)) begin
					status_next = STAT_FULL;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			REQ_REMOVE: begin
				if (count_q == '0) begin
					status_next = STAT_EMPTY;
				end else if (any_match) begin
					count_next = count_q - CNT_W'(1);
				end else begin
					status_next = STAT_NOT_FOUND;
				end
			end
			default: begin
				if (!any_match) begin
					status_next = STAT_NOT_FOUND;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					state_q     <= S_IDLE;
					count_q     <= count_next;
					out_valid_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q        <= req.req_type;
			value_q     <= req.value;
			new_value_q <= req.new_value;
		end
		if (state_q == S_APPLY) begin
			status_q      <= status_next;
			entry_count_q <= 5'(count_next);
		end
	end

endmodule
